// ===== hdl/stsc_pkg.sv =====
package stsc_pkg;

  localparam int IDENT_CHARS = 8;
  localparam int NUMBER_BITS = 32;
  localparam int BUF_W       = IDENT_CHARS * 8;

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // Output queue: power-of-two depth, at least two entries free to take a request.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [4:0] TK_END     = 5'd0;
  localparam logic [4:0] TK_NEWLINE = 5'd1;
  localparam logic [4:0] TK_RARROW  = 5'd2;
  localparam logic [4:0] TK_MINUS   = 5'd3;
  localparam logic [4:0] TK_LARROW  = 5'd4;
  localparam logic [4:0] TK_LESS    = 5'd5;
  localparam logic [4:0] TK_COMMENT = 5'd6;
  localparam logic [4:0] TK_SLASH   = 5'd7;
  localparam logic [4:0] TK_LPAREN  = 5'd8;
  localparam logic [4:0] TK_RPAREN  = 5'd9;
  localparam logic [4:0] TK_LBRACE  = 5'd10;
  localparam logic [4:0] TK_RBRACE  = 5'd11;
  localparam logic [4:0] TK_COMMA   = 5'd12;
  localparam logic [4:0] TK_DOT     = 5'd13;
  localparam logic [4:0] TK_COLON   = 5'd14;
  localparam logic [4:0] TK_PLUS    = 5'd15;
  localparam logic [4:0] TK_STAR    = 5'd16;
  localparam logic [4:0] TK_EQUAL   = 5'd17;
  localparam logic [4:0] TK_GREATER = 5'd18;
  localparam logic [4:0] TK_KW_FN   = 5'd19;
  localparam logic [4:0] TK_KW_LET  = 5'd20;
  localparam logic [4:0] TK_KW_MUT  = 5'd21;
  localparam logic [4:0] TK_KW_RET  = 5'd22;
  localparam logic [4:0] TK_IDENT   = 5'd23;
  localparam logic [4:0] TK_NUMBER  = 5'd24;
  localparam logic [4:0] TK_UNKNOWN = 5'd25;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keyword text packed with the first character in the low byte.
  localparam logic [63:0] KW_FN  = 64'h0000_0000_0000_6E66;
  localparam logic [63:0] KW_LET = 64'h0000_0000_0074_656C;
  localparam logic [63:0] KW_MUT = 64'h0000_0000_0074_756D;
  localparam logic [63:0] KW_RET = 64'h0000_6E72_7574_6572;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [23:0] line_number;
    logic [63:0] ident_text;
    logic [7:0]  text_length;
    logic [31:0] number_value;
    logic        number_overflow;
    logic        last_result;
  } out_t;

  typedef enum logic [5:0] {
    PEND_NONE   = 6'b000001,
    PEND_MINUS  = 6'b000010,
    PEND_LESS   = 6'b000100,
    PEND_SLASH  = 6'b001000,
    PEND_IDENT  = 6'b010000,
    PEND_NUMBER = 6'b100000
  } pend_t;

  // Tokens produced by one input item, oldest in tok0.
  typedef struct packed {
    logic [1:0] count;
    out_t       tok0;
    out_t       tok1;
  } push_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h2C:   k = TK_COMMA;
      8'h2E:   k = TK_DOT;
      8'h3A:   k = TK_COLON;
      8'h2B:   k = TK_PLUS;
      8'h2A:   k = TK_STAR;
      8'h3D:   k = TK_EQUAL;
      8'h3E:   k = TK_GREATER;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic out_t plain_token(logic [4:0] kind, logic [23:0] line);
    out_t t;
    t             = '0;
    t.token_kind  = kind;
    t.line_number = line;
    return t;
  endfunction

endpackage

// ===== hdl/stsc_scan.sv =====
module stsc_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stsc_pkg::in_t  in_data,
  input  logic           q_room,
  output stsc_pkg::push_t push
);

  localparam int NB    = stsc_pkg::NUMBER_BITS;
  localparam int BUF_W = stsc_pkg::BUF_W;

  logic                 s_valid_r, s_valid_nxt;
  stsc_pkg::in_t        s_item_r;
  stsc_pkg::pend_t      pend_r, pend_nxt;
  logic [BUF_W-1:0]     buf_r, buf_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [NB-1:0]        acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [23:0]          line_r, line_nxt;
  logic [23:0]          tsl_r, tsl_nxt;

  logic                 advance;
  logic                 at_end;
  logic [7:0]           c;
  logic                 ext;
  logic                 f_v, g_v;
  stsc_pkg::out_t       f_tok, g_tok;
  logic [63:0]          buf_wide;
  logic [63:0]          acc_wide;
  logic [4:0]           kw;
  logic [NB:0]          dig_res;

  function automatic logic [BUF_W-1:0] add_char(logic [BUF_W-1:0] b, logic [7:0] n,
                                                logic [7:0] ch);
    logic [BUF_W-1:0] r;
    r = b;
    for (int i = 0; i < stsc_pkg::IDENT_CHARS; i++) begin
      if (n == 8'(i)) r[i*8 +: 8] = ch;
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] n);
    return (n == 8'hFF) ? n : n + 8'd1;
  endfunction

  // Returns {overflow, accumulator}; ten times is a shift-add.
  function automatic logic [NB:0] add_digit(logic [NB-1:0] a, logic o, logic [7:0] ch);
    logic [NB+3:0] wide;
    logic [NB+3:0] prod;
    logic [NB:0]   r;
    wide = (NB+4)'(a);
    prod = (wide << 3) + (wide << 1) + (NB+4)'(ch[3:0]);
    if (o) begin
      r = {1'b1, a};
    end else if (prod[NB+3:NB] != 4'd0) begin
      r = {1'b1, {NB{1'b1}}};
    end else begin
      r = {1'b0, prod[NB-1:0]};
    end
    return r;
  endfunction

  assign advance  = s_valid_r && q_room;
  assign in_ready = !s_valid_r || q_room;

  assign at_end   = s_item_r.end_marker || (s_item_r.char_byte == stsc_pkg::CH_NUL);
  assign c        = at_end ? stsc_pkg::CH_NUL : s_item_r.char_byte;
  assign buf_wide = 64'(buf_r);
  assign acc_wide = 64'(acc_r);

  always_comb begin
    if (cnt_r == 8'd2 && buf_wide == stsc_pkg::KW_FN) begin
      kw = stsc_pkg::TK_KW_FN;
    end else if (cnt_r == 8'd3 && buf_wide == stsc_pkg::KW_LET) begin
      kw = stsc_pkg::TK_KW_LET;
    end else if (cnt_r == 8'd3 && buf_wide == stsc_pkg::KW_MUT) begin
      kw = stsc_pkg::TK_KW_MUT;
    end else if (cnt_r == 8'd6 && buf_wide == stsc_pkg::KW_RET) begin
      kw = stsc_pkg::TK_KW_RET;
    end else begin
      kw = stsc_pkg::TK_IDENT;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    line_nxt = line_r;
    tsl_nxt  = tsl_r;
    f_v      = 1'b0;
    g_v      = 1'b0;
    f_tok    = '0;
    g_tok    = '0;
    ext      = 1'b0;
    dig_res  = '0;

    // A byte that extends the pending token.
    unique case (pend_r)
      stsc_pkg::PEND_MINUS: begin
        if (c == stsc_pkg::CH_GT) begin
          ext      = 1'b1;
          g_v      = 1'b1;
          g_tok    = stsc_pkg::plain_token(stsc_pkg::TK_RARROW, tsl_r);
          pend_nxt = stsc_pkg::PEND_NONE;
        end
      end
      stsc_pkg::PEND_LESS: begin
        if (c == stsc_pkg::CH_MINUS) begin
          ext      = 1'b1;
          g_v      = 1'b1;
          g_tok    = stsc_pkg::plain_token(stsc_pkg::TK_LARROW, tsl_r);
          pend_nxt = stsc_pkg::PEND_NONE;
        end
      end
      stsc_pkg::PEND_SLASH: begin
        if (c == stsc_pkg::CH_SLASH) begin
          ext      = 1'b1;
          g_v      = 1'b1;
          g_tok    = stsc_pkg::plain_token(stsc_pkg::TK_COMMENT, tsl_r);
          pend_nxt = stsc_pkg::PEND_NONE;
        end
      end
      stsc_pkg::PEND_IDENT: begin
        if (stsc_pkg::is_alpha(c) || stsc_pkg::is_digit(c)) begin
          ext     = 1'b1;
          buf_nxt = add_char(buf_r, cnt_r, c);
          cnt_nxt = sat_inc(cnt_r);
        end
      end
      stsc_pkg::PEND_NUMBER: begin
        if (stsc_pkg::is_digit(c)) begin
          ext     = 1'b1;
          dig_res = add_digit(acc_r, ovf_r, c);
          ovf_nxt = dig_res[NB];
          acc_nxt = dig_res[NB-1:0];
          cnt_nxt = sat_inc(cnt_r);
        end
      end
      default: ;
    endcase

    if (!ext) begin
      // Flush whatever is pending, then scan the byte from a clean state.
      unique case (pend_r)
        stsc_pkg::PEND_MINUS: begin
          f_v   = 1'b1;
          f_tok = stsc_pkg::plain_token(stsc_pkg::TK_MINUS, tsl_r);
        end
        stsc_pkg::PEND_LESS: begin
          f_v   = 1'b1;
          f_tok = stsc_pkg::plain_token(stsc_pkg::TK_LESS, tsl_r);
        end
        stsc_pkg::PEND_SLASH: begin
          f_v   = 1'b1;
          f_tok = stsc_pkg::plain_token(stsc_pkg::TK_SLASH, tsl_r);
        end
        stsc_pkg::PEND_IDENT: begin
          f_v   = 1'b1;
          f_tok = stsc_pkg::plain_token(kw, tsl_r);
          if (kw == stsc_pkg::TK_IDENT) begin
            f_tok.ident_text  = buf_wide;
            f_tok.text_length = cnt_r;
          end
        end
        stsc_pkg::PEND_NUMBER: begin
          f_v                   = 1'b1;
          f_tok                 = stsc_pkg::plain_token(stsc_pkg::TK_NUMBER, tsl_r);
          f_tok.text_length     = cnt_r;
          f_tok.number_value    = acc_wide[31:0];
          f_tok.number_overflow = ovf_r;
        end
        default: ;
      endcase
      pend_nxt = stsc_pkg::PEND_NONE;
      buf_nxt  = '0;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;

      if (at_end) begin
        g_v   = 1'b1;
        g_tok = stsc_pkg::plain_token(stsc_pkg::TK_END, line_r);
      end else if (c == stsc_pkg::CH_SPACE || c == stsc_pkg::CH_TAB) begin
        g_v = 1'b0;
      end else if (c == stsc_pkg::CH_NL) begin
        g_v   = 1'b1;
        g_tok = stsc_pkg::plain_token(stsc_pkg::TK_NEWLINE, line_r);
        if (line_r != stsc_pkg::LINE_MAX) line_nxt = line_r + 24'd1;
      end else if (c == stsc_pkg::CH_MINUS) begin
        pend_nxt = stsc_pkg::PEND_MINUS;
        tsl_nxt  = line_r;
      end else if (c == stsc_pkg::CH_LESS) begin
        pend_nxt = stsc_pkg::PEND_LESS;
        tsl_nxt  = line_r;
      end else if (c == stsc_pkg::CH_SLASH) begin
        pend_nxt = stsc_pkg::PEND_SLASH;
        tsl_nxt  = line_r;
      end else if (stsc_pkg::is_alpha(c)) begin
        pend_nxt = stsc_pkg::PEND_IDENT;
        tsl_nxt  = line_r;
        buf_nxt  = add_char('0, 8'd0, c);
        cnt_nxt  = 8'd1;
      end else if (stsc_pkg::is_digit(c)) begin
        pend_nxt = stsc_pkg::PEND_NUMBER;
        tsl_nxt  = line_r;
        acc_nxt  = NB'(c[3:0]);
        cnt_nxt  = 8'd1;
      end else begin
        g_v   = 1'b1;
        g_tok = stsc_pkg::plain_token(stsc_pkg::punct_kind(c), line_r);
      end
    end
  end

  always_comb begin
    push      = '0;
    push.tok1 = g_tok;
    push.tok0 = f_v ? f_tok : g_tok;
    if (advance) push.count = {1'b0, f_v} + {1'b0, g_v};
    if (push.count == 2'd2) begin
      push.tok1.last_result = 1'b1;
    end else begin
      push.tok0.last_result = 1'b1;
    end
  end

  assign s_valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      pend_r    <= stsc_pkg::PEND_NONE;
      buf_r     <= '0;
      cnt_r     <= '0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      line_r    <= 24'd1;
      tsl_r     <= 24'd1;
    end else begin
      s_valid_r <= s_valid_nxt;
      if (advance) begin
        pend_r <= pend_nxt;
        buf_r  <= buf_nxt;
        cnt_r  <= cnt_nxt;
        acc_r  <= acc_nxt;
        ovf_r  <= ovf_nxt;
        line_r <= line_nxt;
        tsl_r  <= tsl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s_item_r <= in_data;
  end

  // The end token leaves the scanner with nothing pending.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && at_end) |=> (pend_r == stsc_pkg::PEND_NONE && cnt_r == 8'd0))
    else $error("pending token survived the end of input");

  // The line count only ever moves forward by one, on a newline.
  a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != $past(line_r)) |->
      (line_r == $past(line_r) + 24'd1 && $past(advance) && $past(c) == stsc_pkg::CH_NL))
    else $error("line count changed without a newline");

endmodule

// ===== hdl/stsc_outq.sv =====
module stsc_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  stsc_pkg::push_t push,
  output logic            q_room,
  output logic            out_valid,
  input  logic            out_ready,
  output stsc_pkg::out_t  out_data
);

  localparam int PW = stsc_pkg::QPTR_W;
  localparam int CW = stsc_pkg::QCNT_W;

  stsc_pkg::out_t  mem_r [stsc_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   wr_ptr_1;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr_r + PW'(1);

  // Room for two more tokens, counting the one leaving this cycle.
  assign q_room = (cnt_r <= CW'(stsc_pkg::QDEPTH - 2)) ||
                  (cnt_r == CW'(stsc_pkg::QDEPTH - 1) && pop);

  assign wr_ptr_nxt = wr_ptr_r + PW'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.count == 2'd2) mem_r[wr_ptr_1] <= push.tok1;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> q_room)
    else $error("tokens pushed without room in the queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(stsc_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |-> (!push.tok0.last_result && push.tok1.last_result))
    else $error("last mark not on the second token of a pair");

endmodule

// ===== hdl/source_token_scanner_top.sv =====
// Path: a byte accepted is held in the scanner's item register and scanned from
// there; its tokens go into the output queue and are shown on out_data from it.
// Throughput: one byte per cycle while the queue has room; bytes giving two tokens are
// absorbed by a 4-entry queue; out_ready sets the long-run rate at one token per cycle.
// Reset: synchronous rst_n clears the queue, nothing pending, line count back to one.
module source_token_scanner_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stsc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output stsc_pkg::out_t out_data
);

  stsc_pkg::push_t push;
  logic            q_room;

  stsc_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_room   (q_room),
    .push     (push)
  );

  stsc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_room    (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
